### rtl/dhf_pkg.sv
// ----------------------------------------------------------------------------
// Depth hole fill and spike filter package
// Shared types, register indexes, kinds and the per-pixel filter function.
// ----------------------------------------------------------------------------
`default_nettype none

package dhf_pkg;

    localparam int FRAME_WIDTH_W     = 12;
    localparam int FRAME_HEIGHT_W    = 13;
    localparam int THRESHOLD_W       = 8;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 13;
    localparam int PIXEL_W           = 8;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET     = 12'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET    = 13'd480;
    localparam logic [THRESHOLD_W-1:0]    SPIKE_THRESHOLD_RESET = 8'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPIKE_THRESHOLD = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam int BORDER_PIXELS = 2;

    localparam int RES_FIFO_DEPTH = 3;
    localparam int RES_PTR_W      = 2;

    typedef struct packed {
        logic [PIXEL_W-1:0] upper;
        logic [PIXEL_W-1:0] middle;
    } line_pair_t;

    typedef struct packed {
        logic drain;
        logic fire;
        logic col0;
        logic interior;
        logic eor;
        logic eof;
        logic from_upper;
    } stage_ctl_t;

    typedef struct packed {
        logic               eof;
        logic               eor;
        logic [PIXEL_W-1:0] depth;
    } result_t;

    function automatic logic [PIXEL_W-1:0] filter_pixel(
        input logic [PIXEL_W-1:0]     cen,
        input logic [PIXEL_W-1:0]     lft,
        input logic [PIXEL_W-1:0]     rgt,
        input logic [PIXEL_W-1:0]     abv,
        input logic [PIXEL_W-1:0]     blw,
        input logic [THRESHOLD_W-1:0] th
    );
        logic [PIXEL_W:0]   cen_x;
        logic [PIXEL_W:0]   lft_lim;
        logic [PIXEL_W:0]   rgt_lim;
        logic [PIXEL_W:0]   abv_lim;
        logic [PIXEL_W:0]   blw_lim;
        logic [PIXEL_W:0]   h_sum;
        logic [PIXEL_W:0]   v_sum;
        logic               h_spike;
        logic               v_spike;
        logic [PIXEL_W-1:0] res;
        cen_x   = {1'b0, cen};
        lft_lim = {1'b0, lft} + {1'b0, th};
        rgt_lim = {1'b0, rgt} + {1'b0, th};
        abv_lim = {1'b0, abv} + {1'b0, th};
        blw_lim = {1'b0, blw} + {1'b0, th};
        h_sum   = {1'b0, lft} + {1'b0, rgt};
        v_sum   = {1'b0, abv} + {1'b0, blw};
        h_spike = (lft != '0) && (rgt != '0) && (cen_x > lft_lim) && (cen_x > rgt_lim);
        v_spike = (abv != '0) && (blw != '0) && (cen_x > abv_lim) && (cen_x > blw_lim);
        if (cen == '0) begin
            res = (abv != '0) ? abv : lft;
        end else if (h_spike) begin
            res = h_sum[PIXEL_W:1];
        end else if (v_spike) begin
            res = v_sum[PIXEL_W:1];
        end else begin
            res = cen;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/depth_hole_fill_spike_filter_top.sv
// ----------------------------------------------------------------------------
// Depth hole fill and spike filter
// Streaming depth cleanup on a plus-shaped neighbourhood with a two-pixel border, using two line stores.
// ----------------------------------------------------------------------------
// The block takes one pixel or drain transfer per clock cycle while the result
// queue has room, and gives one filtered pixel per input pixel in raster order.
// A pixel comes out after one row plus one pixel of further input, passing
// through the registered line store read and the result queue; at the end of
// a frame, drain transfers push out the pending pixels one per cycle while the
// queue has room. The rate is set by the two line memories, each read once
// per cycle and written back at that column. The line stores need no clearing
// pass after reset. Writing frame_width or frame_height restarts the stream.
`default_nettype none

module depth_hole_fill_spike_filter_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,  // depth_in
    input  wire logic                              s_axis_tuser,  // kind
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [7:0]                             m_axis_tdata,  // depth_out
    output logic                                   m_axis_tlast,  // end_of_row
    output logic                                   m_axis_tuser,  // end_of_frame
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dhf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [dhf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int HLW = $clog2(MAX_WIDTH + 2);
    localparam int PW  = dhf_pkg::RES_PTR_W;

    localparam logic [PW-1:0] PTR_LAST  = PW'(dhf_pkg::RES_FIFO_DEPTH - 1);
    localparam logic [PW:0]   FIFO_FULL = (PW + 1)'(dhf_pkg::RES_FIFO_DEPTH);
    localparam logic [PW:0]   FIFO_ROOM = (PW + 1)'(dhf_pkg::RES_FIFO_DEPTH - 1);

    logic [dhf_pkg::FRAME_WIDTH_W-1:0]  frame_width_reg,  frame_width_next;
    logic [dhf_pkg::FRAME_HEIGHT_W-1:0] frame_height_reg, frame_height_next;
    logic [dhf_pkg::THRESHOLD_W-1:0]    threshold_reg,    threshold_next;

    logic [CW-1:0]  in_col_reg,  in_col_next;
    logic [RW-1:0]  in_row_reg,  in_row_next;
    logic [CW-1:0]  out_col_reg, out_col_next;
    logic [RW-1:0]  out_row_reg, out_row_next;
    logic [HLW-1:0] held_reg,    held_next;

    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic [HLW-1:0] w_plus1;
    logic [HLW-1:0] drain_addr;

    logic cfg_wr;
    logic in_accept;
    logic is_drain;
    logic fire;
    logic drain_go;
    logic emit;
    logic eor;
    logic eof;
    logic interior;
    logic in_col_last;
    logic in_row_last;

    logic                s1_valid_reg, s1_valid_next;
    dhf_pkg::stage_ctl_t s1_ctl_reg,   s1_ctl_next;
    logic [7:0]          s1_pix_reg;
    logic [CW-1:0]       s1_addr_reg;

    logic                rd_en;
    logic [CW-1:0]       rd_addr;
    logic                wr_en;
    dhf_pkg::line_pair_t wr_data;
    dhf_pkg::line_pair_t rd_data;

    logic [7:0] tap0_reg,  tap0_next;
    logic [7:0] tap1_reg,  tap1_next;
    logic [7:0] tap2_reg,  tap2_next;
    logic [7:0] above_reg, above_next;
    logic [7:0] prev_reg,  prev_next;

    dhf_pkg::result_t result;
    logic             push;
    logic             pop;

    dhf_pkg::result_t fifo_mem_reg [dhf_pkg::RES_FIFO_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      fifo_cnt_reg, fifo_cnt_next;

    // Effective frame size.
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(frame_width_reg);
        end
        if (frame_height_reg == '0)
        begin
            h_eff = HW'(1);
        end
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(frame_height_reg);
        end
    end

    assign cfg_ready     = 1'b1;
    assign cfg_wr        = cfg_valid && cfg_ready;
    assign s_axis_tready = (fifo_cnt_reg + (PW + 1)'(s1_valid_reg)) <= FIFO_ROOM;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_drain      = (s_axis_tuser == dhf_pkg::KIND_DRAIN);

    // Input-side control: position counters, fill count and output position.
    always_comb
    begin
        w_plus1     = HLW'(w_eff) + HLW'(1);
        fire        = (held_reg == w_plus1);
        drain_go    = is_drain && (in_col_reg == '0) && (in_row_reg == '0)
                      && (held_reg != '0);
        emit        = (!is_drain && fire) || drain_go;
        eor         = ((WW + 1)'(out_col_reg) + (WW + 1)'(1)) >= (WW + 1)'(w_eff);
        eof         = eor && (((HW + 1)'(out_row_reg) + (HW + 1)'(1))
                              >= (HW + 1)'(h_eff));
        interior    = (out_row_reg >= RW'(dhf_pkg::BORDER_PIXELS))
                      && (((HW + 1)'(out_row_reg) + (HW + 1)'(dhf_pkg::BORDER_PIXELS))
                          < (HW + 1)'(h_eff))
                      && (out_col_reg >= CW'(dhf_pkg::BORDER_PIXELS))
                      && (((WW + 1)'(out_col_reg) + (WW + 1)'(dhf_pkg::BORDER_PIXELS))
                          < (WW + 1)'(w_eff));
        in_col_last = ((WW + 1)'(in_col_reg) + (WW + 1)'(1)) >= (WW + 1)'(w_eff);
        in_row_last = ((HW + 1)'(in_row_reg) + (HW + 1)'(1)) >= (HW + 1)'(h_eff);

        if (held_reg > HLW'(w_eff))
        begin
            drain_addr = HLW'(w_eff) - HLW'(1);
        end
        else
        begin
            drain_addr = HLW'(w_eff) - held_reg;
        end

        rd_en   = in_accept && (!is_drain || drain_go);
        rd_addr = is_drain ? drain_addr[CW-1:0] : in_col_reg;

        s1_valid_next          = rd_en;
        s1_ctl_next.drain      = is_drain;
        s1_ctl_next.fire       = fire;
        s1_ctl_next.col0       = (in_col_reg == '0);
        s1_ctl_next.interior   = interior;
        s1_ctl_next.eor        = eor;
        s1_ctl_next.eof        = eof;
        s1_ctl_next.from_upper = (held_reg > HLW'(w_eff));
    end

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        threshold_next    = threshold_reg;
        in_col_next       = in_col_reg;
        in_row_next       = in_row_reg;
        out_col_next      = out_col_reg;
        out_row_next      = out_row_reg;
        held_next         = held_reg;
        if (cfg_wr)
        begin
            unique case (cfg_index)
                dhf_pkg::REG_FRAME_WIDTH:
                begin
                    frame_width_next = cfg_data[dhf_pkg::FRAME_WIDTH_W-1:0];
                    in_col_next      = '0;
                    in_row_next      = '0;
                    out_col_next     = '0;
                    out_row_next     = '0;
                    held_next        = '0;
                end
                dhf_pkg::REG_FRAME_HEIGHT:
                begin
                    frame_height_next = cfg_data[dhf_pkg::FRAME_HEIGHT_W-1:0];
                    in_col_next       = '0;
                    in_row_next       = '0;
                    out_col_next      = '0;
                    out_row_next      = '0;
                    held_next         = '0;
                end
                dhf_pkg::REG_SPIKE_THRESHOLD:
                begin
                    threshold_next = cfg_data[dhf_pkg::THRESHOLD_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (in_accept)
        begin
            if (!is_drain)
            begin
                if (!fire)
                begin
                    held_next = held_reg + HLW'(1);
                end
                if (in_col_last)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_last ? '0 : in_row_reg + RW'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + CW'(1);
                end
            end
            else if (drain_go)
            begin
                held_next = held_reg - HLW'(1);
            end
            if (emit)
            begin
                if (eor)
                begin
                    out_col_next = '0;
                    out_row_next = eof ? '0 : out_row_reg + RW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= dhf_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= dhf_pkg::FRAME_HEIGHT_RESET;
            threshold_reg    <= dhf_pkg::SPIKE_THRESHOLD_RESET;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            held_reg         <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            threshold_reg    <= threshold_next;
            in_col_reg       <= in_col_next;
            in_row_reg       <= in_row_next;
            out_col_reg      <= out_col_next;
            out_row_reg      <= out_row_next;
            held_reg         <= held_next;
            s1_valid_reg     <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_ctl_reg  <= s1_ctl_next;
            s1_pix_reg  <= s_axis_tdata;
            s1_addr_reg <= rd_addr;
        end
    end

    dhf_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // Window stage: the read pair arrives and the result is formed; for pixels
    // the taps shift and the line stores take the rotated column.
    always_comb
    begin
        tap0_next      = tap0_reg;
        tap1_next      = tap1_reg;
        tap2_next      = tap2_reg;
        above_next     = above_reg;
        prev_next      = prev_reg;
        wr_en          = s1_valid_reg && !s1_ctl_reg.drain;
        wr_data.upper  = rd_data.middle;
        wr_data.middle = s1_pix_reg;
        result.eor     = s1_ctl_reg.eor;
        result.eof     = s1_ctl_reg.eof;
        result.depth   = tap2_reg;
        if (s1_ctl_reg.drain)
        begin
            result.depth = s1_ctl_reg.from_upper ? rd_data.upper : rd_data.middle;
        end
        else
        begin
            if (!s1_ctl_reg.col0 && s1_ctl_reg.interior)
            begin
                result.depth = dhf_pkg::filter_pixel(tap2_reg, tap1_reg, rd_data.middle,
                                                     above_reg, prev_reg, threshold_reg);
            end
            if (s1_valid_reg)
            begin
                tap0_next  = tap1_reg;
                tap1_next  = tap2_reg;
                tap2_next  = rd_data.middle;
                above_next = rd_data.upper;
                prev_next  = s1_pix_reg;
            end
        end
        push = s1_valid_reg && (s1_ctl_reg.drain || s1_ctl_reg.fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap0_reg  <= '0;
            tap1_reg  <= '0;
            tap2_reg  <= '0;
            above_reg <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            tap0_reg  <= tap0_next;
            tap1_reg  <= tap1_next;
            tap2_reg  <= tap2_next;
            above_reg <= above_next;
            prev_reg  <= prev_next;
        end
    end

    // Result queue.
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (fifo_cnt_reg != '0);
    assign m_axis_tdata  = fifo_mem_reg[rd_ptr_reg].depth;
    assign m_axis_tlast  = fifo_mem_reg[rd_ptr_reg].eor;
    assign m_axis_tuser  = fifo_mem_reg[rd_ptr_reg].eof;

    always_comb
    begin
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        fifo_cnt_next = fifo_cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fifo_cnt_next = fifo_cnt_reg + (PW + 1)'(1);
        end
        else if (pop && !push)
        begin
            fifo_cnt_next = fifo_cnt_reg - (PW + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (fifo_cnt_reg == FIFO_FULL)) |-> pop)
        else $error("result queue overflow");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= w_plus1)
        else $error("pending pixel count exceeds one row plus one");

    a_columns_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((WW + 1)'(in_col_reg) < (WW + 1)'(w_eff))
        && ((WW + 1)'(out_col_reg) < (WW + 1)'(w_eff)))
        else $error("column counter beyond frame width");

    a_window_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && !is_drain) |=> (wr_en && (s1_addr_reg == $past(in_col_reg))))
        else $error("line store write lost its column");
`endif

endmodule

`default_nettype wire

### rtl/dhf_line_store.sv
// ----------------------------------------------------------------------------
// Line store pair
// Two synchronous line memories sharing one read and one write address, with
// a bypass for a write that lands on the entry read in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dhf_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rd_en,
    input  wire logic [AW-1:0]       rd_addr,
    input  wire logic                wr_en,
    input  wire logic [AW-1:0]       wr_addr,
    input  wire dhf_pkg::line_pair_t wr_data,
    output dhf_pkg::line_pair_t      rd_data
);

    logic [dhf_pkg::PIXEL_W-1:0] upper_mem  [DEPTH];
    logic [dhf_pkg::PIXEL_W-1:0] middle_mem [DEPTH];

    dhf_pkg::line_pair_t mem_q_reg;
    dhf_pkg::line_pair_t fwd_data_reg;
    logic                fwd_hit_reg;
    logic                fwd_hit_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_data.upper;
            middle_mem[wr_addr] <= wr_data.middle;
        end
        if (rd_en)
        begin
            mem_q_reg.upper  <= upper_mem[rd_addr];
            mem_q_reg.middle <= middle_mem[rd_addr];
            fwd_data_reg     <= wr_data;
        end
    end

    // A read that meets a write to the same entry returns the old word, so
    // the freshly written word is kept aside and returned instead.
    always_comb
    begin
        fwd_hit_next = fwd_hit_reg;
        if (rd_en)
        begin
            fwd_hit_next = wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Depth hole fill and spike filter testbench
// Drives depth frames and drain transfers through the stream input under
// random sender gaps and receiver stalls, predicts each filtered pixel from an
// independent line-store model or a typed row, and checks outputs in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_W       = 2048;
    localparam int MAX_H       = 4096;
    localparam int RAND_PHASES = 9;
    localparam int BIG_W_PHASE = 3;
    localparam int BIG_H_PHASE = 6;
    localparam int IDLE_SETTLE = 8;
    localparam int END_SETTLE  = 32;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [dhf_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic K_PIX = dhf_pkg::KIND_PIXEL;
    localparam logic K_DRN = dhf_pkg::KIND_DRAIN;

    typedef struct packed {
        logic [dhf_pkg::PIXEL_W-1:0] depth;
        logic                        eor;
        logic                        eof;
    } pix_result_t;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_op_t;

    typedef struct {
        row_op_t                         op;
        logic [dhf_pkg::CFG_INDEX_W-1:0] reg_index;
        logic [dhf_pkg::CFG_DATA_W-1:0]  reg_data;
        logic                            kind;
        logic [dhf_pkg::PIXEL_W-1:0]     depth;
        bit                              typed;
        pix_result_t                     want;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata = '0;
    logic                            s_axis_tuser = dhf_pkg::KIND_PIXEL;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [7:0]                      m_axis_tdata;
    logic                            m_axis_tlast;
    logic                            m_axis_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [dhf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [dhf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    depth_hole_fill_spike_filter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    logic [dhf_pkg::PIXEL_W-1:0]        older_row_store [MAX_W];
    logic [dhf_pkg::PIXEL_W-1:0]        newer_row_store [MAX_W];
    logic [dhf_pkg::PIXEL_W-1:0]        window_taps [3];
    logic [dhf_pkg::PIXEL_W-1:0]        above_px;
    logic [dhf_pkg::PIXEL_W-1:0]        last_in_px;
    int unsigned                        in_col;
    int unsigned                        in_row_cnt;
    int unsigned                        out_col;
    int unsigned                        out_row_cnt;
    int unsigned                        backlog;
    logic [dhf_pkg::FRAME_WIDTH_W-1:0]  width_reg  = dhf_pkg::FRAME_WIDTH_RESET;
    logic [dhf_pkg::FRAME_HEIGHT_W-1:0] height_reg = dhf_pkg::FRAME_HEIGHT_RESET;
    logic [dhf_pkg::THRESHOLD_W-1:0]    thresh_reg = dhf_pkg::SPIKE_THRESHOLD_RESET;

    pix_result_t expected_pixels [$];
    int          error_count = 0;
    int          out_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;

    stim_row_t directed_rows [27] = '{
        '{ROW_CFG,  dhf_pkg::REG_FRAME_WIDTH,  13'h1002, K_PIX, 8'h00, 1'b0, 10'd0},
        '{ROW_CFG,  dhf_pkg::REG_FRAME_HEIGHT, 13'h0000, K_PIX, 8'h00, 1'b0, 10'd0},
        '{ROW_CFG,  dhf_pkg::REG_SPIKE_THRESHOLD, 13'h00FF, K_PIX, 8'h00, 1'b0, 10'd0},
        '{ROW_CFG,  REG_UNUSED, 13'h1FFF, K_PIX, 8'h00, 1'b0, 10'd0},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_DRN, 8'hFF, 1'b0, 10'd0},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_PIX, 8'h00, 1'b0, 10'd0},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_PIX, 8'hFF, 1'b0, 10'd0},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_PIX, 8'h01, 1'b0, 10'd0},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_PIX, 8'h55, 1'b1, {8'h00, 1'b0, 1'b0}},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_PIX, 8'hAA, 1'b1, {8'hFF, 1'b1, 1'b1}},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_PIX, 8'h80, 1'b1, {8'h01, 1'b0, 1'b0}},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_DRN, 8'h00, 1'b1, {8'h55, 1'b1, 1'b1}},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_DRN, 8'h00, 1'b0, 10'd0},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_DRN, 8'h00, 1'b0, 10'd0},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_DRN, 8'h7F, 1'b0, 10'd0},
        '{ROW_CFG,  dhf_pkg::REG_FRAME_WIDTH,  13'h0000, K_PIX, 8'h00, 1'b0, 10'd0},
        '{ROW_CFG,  dhf_pkg::REG_FRAME_HEIGHT, 13'h0002, K_PIX, 8'h00, 1'b0, 10'd0},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_PIX, 8'h10, 1'b0, 10'd0},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_PIX, 8'h20, 1'b0, 10'd0},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_PIX, 8'h30, 1'b1, {8'h10, 1'b1, 1'b0}},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_PIX, 8'h40, 1'b1, {8'h20, 1'b1, 1'b1}},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_PIX, 8'h50, 1'b0, 10'd0},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_DRN, 8'h00, 1'b0, 10'd0},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_PIX, 8'h60, 1'b0, 10'd0},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_DRN, 8'h00, 1'b0, 10'd0},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_DRN, 8'h00, 1'b0, 10'd0},
        '{ROW_ITEM, REG_UNUSED, 13'h0, K_DRN, 8'h00, 1'b0, 10'd0}
    };

    function automatic int unsigned eff_width();
        if (width_reg == '0)
            return 1;
        if (width_reg > MAX_W)
            return MAX_W;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == '0)
            return 1;
        if (height_reg > MAX_H)
            return MAX_H;
        return height_reg;
    endfunction

    function automatic void restart_stream();
        in_col      = 0;
        in_row_cnt  = 0;
        out_col     = 0;
        out_row_cnt = 0;
        backlog     = 0;
    endfunction

    function automatic void apply_register(input logic [dhf_pkg::CFG_INDEX_W-1:0] idx,
                                           input logic [dhf_pkg::CFG_DATA_W-1:0] data);
        if (idx == dhf_pkg::REG_FRAME_WIDTH)
        begin
            width_reg = data[dhf_pkg::FRAME_WIDTH_W-1:0];
            restart_stream();
        end
        else if (idx == dhf_pkg::REG_FRAME_HEIGHT)
        begin
            height_reg = data[dhf_pkg::FRAME_HEIGHT_W-1:0];
            restart_stream();
        end
        else if (idx == dhf_pkg::REG_SPIKE_THRESHOLD)
        begin
            thresh_reg = data[dhf_pkg::THRESHOLD_W-1:0];
        end
    endfunction

    function automatic logic [dhf_pkg::PIXEL_W-1:0] clean_pixel(
        input logic [dhf_pkg::PIXEL_W-1:0] cen,
        input logic [dhf_pkg::PIXEL_W-1:0] lft,
        input logic [dhf_pkg::PIXEL_W-1:0] rgt,
        input logic [dhf_pkg::PIXEL_W-1:0] abv,
        input logic [dhf_pkg::PIXEL_W-1:0] blw
    );
        int th;
        int c;
        th = int'(thresh_reg);
        c  = int'(cen);
        if (cen == '0)
            return (abv != '0) ? abv : lft;
        if (lft != '0 && rgt != '0 && c - int'(lft) > th && c - int'(rgt) > th)
            return dhf_pkg::PIXEL_W'((int'(lft) + int'(rgt)) / 2);
        if (abv != '0 && blw != '0 && c - int'(abv) > th && c - int'(blw) > th)
            return dhf_pkg::PIXEL_W'((int'(abv) + int'(blw)) / 2);
        return cen;
    endfunction

    function automatic pix_result_t emit_pixel(input logic [dhf_pkg::PIXEL_W-1:0] val,
                                               input int unsigned w, input int unsigned h);
        pix_result_t r;
        r.depth = val;
        r.eor   = (out_col + 1 >= w);
        r.eof   = r.eor && (out_row_cnt + 1 >= h);
        if (r.eor)
        begin
            out_col     = 0;
            out_row_cnt = r.eof ? 0 : out_row_cnt + 1;
        end
        else
        begin
            out_col++;
        end
        return r;
    endfunction

    function automatic bit filter_step(input logic kind,
                                       input logic [dhf_pkg::PIXEL_W-1:0] px,
                                       output pix_result_t res);
        int unsigned                 w;
        int unsigned                 h;
        int unsigned                 c;
        logic [dhf_pkg::PIXEL_W-1:0] a;
        logic [dhf_pkg::PIXEL_W-1:0] m;
        logic [dhf_pkg::PIXEL_W-1:0] prev_t2;
        logic [dhf_pkg::PIXEL_W-1:0] val;
        bit                          fire;
        bit                          interior;
        w   = eff_width();
        h   = eff_height();
        val = '0;
        res = '0;
        if (backlog > w + 1)
            backlog = w + 1;
        if (in_col >= w)
            in_col = 0;
        if (in_row_cnt >= h)
            in_row_cnt = 0;
        if (kind == dhf_pkg::KIND_DRAIN)
        begin
            if (in_row_cnt != 0 || in_col != 0 || backlog == 0)
                return 1'b0;
            val = (backlog > w) ? older_row_store[w-1] : newer_row_store[w-backlog];
            backlog--;
            res = emit_pixel(val, w, h);
            return 1'b1;
        end
        c       = in_col;
        a       = older_row_store[c];
        m       = newer_row_store[c];
        prev_t2 = window_taps[2];
        window_taps[0] = window_taps[1];
        window_taps[1] = window_taps[2];
        window_taps[2] = m;
        fire = (backlog == w + 1);
        if (fire)
        begin
            if (c == 0)
            begin
                val = prev_t2;
            end
            else
            begin
                interior = out_row_cnt >= dhf_pkg::BORDER_PIXELS
                           && out_row_cnt + dhf_pkg::BORDER_PIXELS < h
                           && out_col >= dhf_pkg::BORDER_PIXELS
                           && out_col + dhf_pkg::BORDER_PIXELS < w;
                val = interior ? clean_pixel(window_taps[1], window_taps[0], window_taps[2],
                                             above_px, last_in_px)
                               : window_taps[1];
            end
        end
        above_px           = a;
        older_row_store[c] = m;
        newer_row_store[c] = px;
        last_in_px         = px;
        if (c + 1 >= w)
        begin
            in_col     = 0;
            in_row_cnt = (in_row_cnt + 1 >= h) ? 0 : in_row_cnt + 1;
        end
        else
        begin
            in_col = c + 1;
        end
        if (!fire)
        begin
            backlog++;
            return 1'b0;
        end
        res = emit_pixel(val, w, h);
        return 1'b1;
    endfunction

    function automatic logic [dhf_pkg::PIXEL_W-1:0] frame_pixel(input int base);
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return '0;
        if (pick < 27)
            return dhf_pkg::PIXEL_W'($urandom_range(base, 255));
        v = base + int'($urandom_range(0, 6)) - 3;
        if (v < 1)
            v = 1;
        if (v > 255)
            v = 255;
        return dhf_pkg::PIXEL_W'(v);
    endfunction

    task automatic report_error(input string what);
        error_count++;
        $display("ERROR: output %0d: %s", out_count, what);
    endtask

    task automatic send_item(input logic kind, input logic [dhf_pkg::PIXEL_W-1:0] px,
                             input bit typed, input pix_result_t typed_res);
        pix_result_t res;
        bit          got;
        @(negedge clk);
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        got = filter_step(kind, px, res);
        if (got)
            expected_pixels.insert(expected_pixels.size(), typed ? typed_res : res);
    endtask

    task automatic write_register(input logic [dhf_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [dhf_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle(input int settle);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    always @(negedge clk)
    begin : sink_pattern
        int          tick;
        int          mode;
        logic [15:0] pattern;
        if (tick % 200 == 0)
        begin
            mode    = $urandom_range(0, 2);
            pattern = 16'($urandom) | 16'h0001;
        end
        tick++;
        case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= pattern[tick % 16];
        endcase
    end

    always @(posedge clk)
    begin : check_output
        pix_result_t want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_error($sformatf("unexpected pixel %02h", m_axis_tdata));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (m_axis_tdata !== want.depth)
                    report_error($sformatf("depth %02h, expected %02h",
                                           m_axis_tdata, want.depth));
                if (m_axis_tlast !== want.eor)
                    report_error($sformatf("end_of_row %b, expected %b",
                                           m_axis_tlast, want.eor));
                if (m_axis_tuser !== want.eof)
                    report_error($sformatf("end_of_frame %b, expected %b",
                                           m_axis_tuser, want.eof));
            end
            out_count++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                             order;
        int                             frames;
        int                             npx;
        int                             base;
        int unsigned                    w;
        int unsigned                    h;
        bit                             big;
        bit                             wild;
        bit                             trunc;
        logic [dhf_pkg::CFG_DATA_W-1:0] w_data;
        logic [dhf_pkg::CFG_DATA_W-1:0] h_data;
        logic [dhf_pkg::CFG_DATA_W-1:0] t_data;

        for (int i = 0; i < MAX_W; i++)
        begin
            older_row_store[i] = '0;
            newer_row_store[i] = '0;
        end
        window_taps = '{default: '0};
        above_px    = '0;
        last_in_px  = '0;
        restart_stream();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == ROW_CFG)
            begin
                wait_idle(IDLE_SETTLE);
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
            end
            else
            begin
                send_item(directed_rows[i].kind, directed_rows[i].depth,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_idle(IDLE_SETTLE);
            gaps_on = ($urandom_range(0, 3) != 0);
            big     = (ph == BIG_W_PHASE) || (ph == BIG_H_PHASE);
            if (ph == BIG_W_PHASE)
            begin
                w_data = $urandom_range(0, 1) ? 13'd2048 : 13'h1FFF;
                h_data = 13'd1;
            end
            else if (ph == BIG_H_PHASE)
            begin
                w_data = 13'd1;
                h_data = $urandom_range(0, 1) ? 13'd4096 : 13'h1FFF;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       w_data = 13'd0;
                    1:       w_data = 13'd1;
                    2:       w_data = 13'($urandom_range(2, 4));
                    default: w_data = 13'($urandom_range(5, 9));
                endcase
                w_data[dhf_pkg::CFG_DATA_W-1] = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 7))
                    0:       h_data = 13'd0;
                    1:       h_data = 13'($urandom_range(1, 4));
                    default: h_data = 13'($urandom_range(5, 6));
                endcase
            end
            case ($urandom_range(0, 3))
                0:       t_data = 13'd0;
                1:       t_data = 13'd255;
                2:       t_data = 13'($urandom_range(1, 20));
                default: t_data = 13'($urandom_range(0, 255)) | 13'($urandom_range(0, 1) << 12);
            endcase
            order = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++)
            begin
                case ((order + k) % 3)
                    0:       write_register(dhf_pkg::REG_FRAME_WIDTH, w_data);
                    1:       write_register(dhf_pkg::REG_FRAME_HEIGHT, h_data);
                    default: write_register(dhf_pkg::REG_SPIKE_THRESHOLD, t_data);
                endcase
            end
            if ($urandom_range(0, 4) == 0)
                write_register(REG_UNUSED, 13'($urandom));

            w      = eff_width();
            h      = eff_height();
            frames = big ? 1 : $urandom_range(1, 2);
            trunc  = !big && (ph != RAND_PHASES - 1) && ($urandom_range(0, 5) == 0);
            for (int f = 0; f < frames; f++)
            begin
                base = $urandom_range(1, 220);
                wild = ($urandom_range(0, 4) == 0);
                npx  = big ? $urandom_range(8, 24) : w * h;
                if (trunc && f == frames - 1)
                    npx = $urandom_range(1, npx);
                for (int p = 0; p < npx; p++)
                begin
                    if (!big && $urandom_range(0, 29) == 0)
                        send_item(dhf_pkg::KIND_DRAIN, dhf_pkg::PIXEL_W'($urandom), 1'b0, '0);
                    send_item(dhf_pkg::KIND_PIXEL,
                              wild ? dhf_pkg::PIXEL_W'($urandom) : frame_pixel(base),
                              1'b0, '0);
                end
                if (!big && ((f == frames - 1) ? !trunc : ($urandom_range(0, 1) == 0)))
                begin
                    repeat (w + 1 + $urandom_range(0, 2))
                        send_item(dhf_pkg::KIND_DRAIN, dhf_pkg::PIXEL_W'($urandom), 1'b0, '0);
                end
            end
        end

        wait_idle(END_SETTLE);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
rtl/dhf_pkg.sv
rtl/dhf_line_store.sv
rtl/depth_hole_fill_spike_filter_top.sv
tb/testbench.sv
